[rtl/sil_pkg.sv]
// Shared constants and types for the sorted insertion list.
`timescale 1ns / 1ps

package sil_pkg;

  // List capacity (2 to 32 entries)
  localparam int CAPACITY = 32;

  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = 5;
  localparam int HELD_W = 6;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [HELD_W-1:0]        held_t;

endpackage

[rtl/sorted_insert_list.sv]
// Top level of the sorted insertion list: insert sequencer and list readout.
`timescale 1ns / 1ps

// Each accepted request inserts a signed 32-bit value into a list kept in
// ascending order (equal values go after those already stored) and then
// reads the whole list out, smallest first, one result per cycle while
// out_ready is high. The list holds CAPACITY entries; a request that finds
// it full leaves it unchanged and the readout carries out_rejected on every
// result. The insert walks from the tail toward the head through the single
// read port of the entry store, one compare and one shifted entry per cycle.
// A new request is accepted only after the last result of the previous
// readout has been taken; in_ready is high only between requests. No
// clearing pass is needed after reset.

module sorted_insert_list (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sil_pkg::data_t in_value,
  output logic           out_valid,
  input  logic           out_ready,
  output sil_pkg::data_t out_entry_value,
  output sil_pkg::pos_t  out_position,
  output sil_pkg::held_t out_entries_held,
  output logic           out_last,
  output logic           out_rejected
);
  import sil_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_ERD  = 3'd3;
  localparam logic [2:0] S_EOUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       k_r, k_nxt;
  cnt_t       idx_r, idx_nxt;
  data_t      val_r, val_nxt;
  logic       rej_r, rej_nxt;

  logic  wr_en, rd_en;
  addr_t wr_addr, rd_addr;
  data_t wr_data, rd_data;
  logic  is_last;

  sil_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign is_last = (idx_r + cnt_t'(1)) == cnt_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    rej_nxt   = rej_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = val_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_value;
          k_nxt   = cnt_r;
          if (cnt_r == cnt_t'(CAPACITY)) begin
            rej_nxt   = 1'b1;
            state_nxt = S_ERD;
          end else begin
            rej_nxt   = 1'b0;
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        // head reached: place value at slot 0, else fetch entry below k
        if (k_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          cnt_nxt   = cnt_r + cnt_t'(1);
          state_nxt = S_ERD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = addr_t'(k_r - cnt_t'(1));
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // rd_data holds entry k-1; shift it up if it is greater
        if (rd_data > val_r) begin
          wr_en   = 1'b1;
          wr_addr = addr_t'(k_r);
          wr_data = rd_data;
          k_nxt   = k_r - cnt_t'(1);
          if (k_r == cnt_t'(1)) begin
            state_nxt = S_LOOK;
          end else begin
            rd_en   = 1'b1;
            rd_addr = addr_t'(k_r - cnt_t'(2));
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = addr_t'(k_r);
          cnt_nxt   = cnt_r + cnt_t'(1);
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        idx_nxt   = '0;
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        // present entry idx, fetch the next one on acceptance
        if (out_ready) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + cnt_t'(1);
            rd_en   = 1'b1;
            rd_addr = addr_t'(idx_r + cnt_t'(1));
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    rej_r <= rej_nxt;
  end

  // ports
  assign in_ready         = state_r == S_IDLE;
  assign out_valid        = state_r == S_EOUT;
  assign out_entry_value  = rd_data;
  assign out_position     = pos_t'(idx_r);
  assign out_entries_held = held_t'(cnt_r);
  assign out_last         = is_last;
  assign out_rejected     = rej_r;

endmodule

[rtl/sil_mem.sv]
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module sil_mem (
  input  logic          clk,
  input  logic          wr_en,
  input  sil_pkg::addr_t wr_addr,
  input  sil_pkg::data_t wr_data,
  input  logic          rd_en,
  input  sil_pkg::addr_t rd_addr,
  output sil_pkg::data_t rd_data
);
  import sil_pkg::*;

  data_t mem [CAPACITY];
  data_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
